@@ hw/rtl/byte_pattern_stream_search_core_macros.svh @@
// Assertion macros shared by the search core modules.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef BYTE_PATTERN_STREAM_SEARCH_CORE_MACROS_SVH
`define BYTE_PATTERN_STREAM_SEARCH_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bpss_pkg.sv @@
`timescale 1ns / 1ps

package bpss_pkg;

  // Default configuration of the search core.
  localparam int MAX_NEEDLE_DEF = 16;
  localparam int MAX_HITS_DEF   = 1048576;

  // Depth of the queue between the scanner and the result stage.
  localparam int QDEPTH = 4;

  // Field widths.
  localparam int OFFSET_W = 48;
  localparam int HITS_W   = 21;
  localparam int LEN_W    = 5;
  localparam int CFG_W    = 64;
  localparam int ADDR_W   = 5;

  // Register indexes, taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_NEEDLE_LO  = 2'd0,
    REG_NEEDLE_HI  = 2'd1,
    REG_NEEDLE_LEN = 2'd2,
    REG_HIT_LIMIT  = 2'd3
  } reg_index_t;

  // Results caused by one input byte: an optional hit and an optional summary.
  typedef struct packed {
    logic                hit;
    logic                sum;
    logic [OFFSET_W-1:0] offset;
    logic [HITS_W-1:0]   hits;
    logic                saw;
  } entry_t;

endpackage

@@ hw/rtl/bpss_front.sv @@
`timescale 1ns / 1ps
`include "byte_pattern_stream_search_core_macros.svh"

module bpss_front #(
  parameter int MAX_NEEDLE = bpss_pkg::MAX_NEEDLE_DEF,
  parameter int MAX_HITS   = bpss_pkg::MAX_HITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        byte_unreadable,
  input  logic                        final_byte,
  input  logic [bpss_pkg::CFG_W-1:0]  needle_lo,
  input  logic [bpss_pkg::CFG_W-1:0]  needle_hi,
  input  logic [bpss_pkg::LEN_W-1:0]  needle_len,
  input  logic [bpss_pkg::HITS_W-1:0] hit_limit,
  input  logic                        q_full,
  output logic                        push,
  output bpss_pkg::entry_t            push_entry
);

  localparam int WIN  = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int FW   = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int NLW  = $clog2(MAX_NEEDLE + 1);
  localparam int LW   = (NLW > bpss_pkg::LEN_W) ? NLW : bpss_pkg::LEN_W;
  localparam int HCW  = $clog2(MAX_HITS + 1);
  localparam int CW   = (HCW > bpss_pkg::HITS_W) ? HCW : bpss_pkg::HITS_W;
  localparam int OW   = bpss_pkg::OFFSET_W;

  // Stream state.
  logic [7:0]     window [WIN];
  logic [FW-1:0]  window_fill;
  logic [OW-1:0]  position;
  logic [HCW-1:0] hit_count;
  logic           unreadable_seen;

  logic [7:0]     needle [MAX_NEEDLE];
  logic [7:0]     cand   [MAX_NEEDLE];
  logic [LW-1:0]  len_ext;
  logic           len_ok;
  logic [CW-1:0]  limit_ext;
  logic [CW-1:0]  cap;
  logic           active;
  logic           fill_ok;
  logic           eq;
  logic           hit;
  logic           accept;
  logic [CW-1:0]  hits_now;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Needle bytes; bytes beyond the two registers read as zero.
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (i < 8) begin
        needle[i] = needle_lo[8*i +: 8];
      end else if (i < 16) begin
        needle[i] = needle_hi[8*(i-8) +: 8];
      end else begin
        needle[i] = 8'd0;
      end
    end
  end

  // Candidate bytes: the new byte first, then the history, newest first.
  always_comb begin
    cand[0] = data_byte;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      cand[k] = window[k-1];
    end
  end

  // Scan enable and hit cap.
  assign len_ext   = LW'(needle_len);
  assign len_ok    = (len_ext != '0) && (len_ext <= LW'(MAX_NEEDLE));
  assign limit_ext = CW'(hit_limit);
  assign cap       = ((limit_ext == '0) || (limit_ext > CW'(MAX_HITS))) ?
                     CW'(MAX_HITS) : limit_ext;
  assign active    = len_ok && (CW'(hit_count) < cap);
  assign fill_ok   = (LW'(window_fill) + LW'(1)) >= len_ext;

  // Parallel compare: candidate k is matched against needle byte len-1-k.
  always_comb begin
    logic [LW-1:0] nidx;
    eq   = 1'b1;
    nidx = '0;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      if (LW'(k) < len_ext) begin
        nidx = len_ext - LW'(1) - LW'(k);
        if (cand[k] != needle[nidx[FW-1:0]]) begin
          eq = 1'b0;
        end
      end
    end
  end

  assign hit      = active && !byte_unreadable && fill_ok && eq;
  assign hits_now = CW'(hit_count) + CW'(hit);

  // Record for the queue.
  assign push              = accept && (hit || final_byte);
  assign push_entry.hit    = hit;
  assign push_entry.sum    = final_byte;
  assign push_entry.offset = position - OW'(len_ext - LW'(1));
  assign push_entry.hits   = hits_now[bpss_pkg::HITS_W-1:0];
  assign push_entry.saw    = unreadable_seen || (active && byte_unreadable);

  // Control state of the stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill     <= '0;
      position        <= '0;
      hit_count       <= '0;
      unreadable_seen <= 1'b0;
    end else if (accept) begin
      if (final_byte) begin
        window_fill     <= '0;
        position        <= '0;
        hit_count       <= '0;
        unreadable_seen <= 1'b0;
      end else begin
        position <= position + OW'(1);
        if (hit) begin
          hit_count <= hit_count + HCW'(1);
        end
        if (active && byte_unreadable) begin
          unreadable_seen <= 1'b1;
          window_fill     <= '0;
        end else if (active && (window_fill < FW'(MAX_NEEDLE - 1))) begin
          window_fill <= window_fill + FW'(1);
        end
      end
    end
  end

  // History bytes; only entries below the fill count are ever compared.
  always_ff @(posedge clk) begin
    if (accept && active && !byte_unreadable) begin
      window[0] <= data_byte;
      for (int j = 1; j < WIN; j++) begin
        window[j] <= window[j-1];
      end
    end
  end

  `BPSS_ASSERT_NEXT(a_final_clears, accept && final_byte,
    position == '0 && hit_count == '0 && !unreadable_seen,
    "stream state not cleared after the final byte")
  `BPSS_ASSERT_NEXT(a_stall_holds, in_valid && !in_ready, $stable(position),
    "stream position moved while the input was stalled")

endmodule

@@ hw/rtl/bpss_queue.sv @@
`timescale 1ns / 1ps
`include "byte_pattern_stream_search_core_macros.svh"

module bpss_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bpss_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output bpss_pkg::entry_t head
);

  localparam int DEPTH = bpss_pkg::QDEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW   = $clog2(DEPTH + 1);

  bpss_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `BPSS_ASSERT_SAME(a_count_bound, 1'b1, count <= CNW'(DEPTH),
    "queue occupancy above its depth")
  `BPSS_ASSERT_NEXT(a_pop_drains, do_pop && !do_push,
    count == $past(count) - CNW'(1), "queue occupancy did not drop on a pop")

endmodule

@@ hw/rtl/bpss_back.sv @@
`timescale 1ns / 1ps
`include "byte_pattern_stream_search_core_macros.svh"

module bpss_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  bpss_pkg::entry_t              q_head,
  output logic                          pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          is_summary,
  output logic [bpss_pkg::OFFSET_W-1:0] match_offset,
  output logic [bpss_pkg::HITS_W-1:0]   hits_found,
  output logic                          saw_unreadable,
  output logic                          last_of_run
);

  logic                        load;
  logic                        pending;
  logic [bpss_pkg::HITS_W-1:0] pend_hits;
  logic                        pend_saw;

  // The output register takes a new result when empty or being drained.
  assign load = !out_valid || out_ready;
  assign pop  = load && !pending && !q_empty;

  // Output valid and the pending summary flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        pending   <= q_head.hit && q_head.sum;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; a hit goes out before the summary of the same byte.
  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        is_summary     <= 1'b1;
        match_offset   <= '0;
        hits_found     <= pend_hits;
        saw_unreadable <= pend_saw;
        last_of_run    <= 1'b1;
      end else if (!q_empty) begin
        pend_hits <= q_head.hits;
        pend_saw  <= q_head.saw;
        if (q_head.hit) begin
          is_summary     <= 1'b0;
          match_offset   <= q_head.offset;
          hits_found     <= '0;
          saw_unreadable <= 1'b0;
          last_of_run    <= !q_head.sum;
        end else begin
          is_summary     <= 1'b1;
          match_offset   <= '0;
          hits_found     <= q_head.hits;
          saw_unreadable <= q_head.saw;
          last_of_run    <= 1'b1;
        end
      end
    end
  end

  `BPSS_ASSERT_SAME(a_pending_after_hit, pending,
    out_valid && !is_summary && !last_of_run,
    "summary pending without a hit in the output register")

endmodule

@@ hw/rtl/byte_pattern_stream_search_core.sv @@
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// in       in_valid / in_ready       data_byte, byte_unreadable, final_byte
// out      out_valid / out_ready     is_summary, match_offset, hits_found,
//                                    saw_unreadable, last_of_run
// cfg      psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// One byte is accepted per cycle while the result queue is not full; the needle
// compare runs in parallel over the history window in the accept cycle.
// A byte that causes results passes through the result queue into the output
// register, which raises out_valid when free; a byte with both a hit and a
// summary occupies the output register for two transactions, one per result.
// Input ready drops only when the four-entry result queue is full.
// Reset is synchronous and clears the stream counters, the queue and the output
// valid flag; no clearing pass is needed.

module byte_pattern_stream_search_core #(
  parameter int MAX_NEEDLE = bpss_pkg::MAX_NEEDLE_DEF,
  parameter int MAX_HITS   = bpss_pkg::MAX_HITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          byte_unreadable,
  input  logic                          final_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_summary,
  output logic [bpss_pkg::OFFSET_W-1:0] match_offset,
  output logic [bpss_pkg::HITS_W-1:0]   hits_found,
  output logic                          saw_unreadable,
  output logic                          last_of_run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpss_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpss_pkg::CFG_W-1:0]    pwdata,
  output logic [bpss_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);

  logic [bpss_pkg::CFG_W-1:0]  needle_lo;
  logic [bpss_pkg::CFG_W-1:0]  needle_hi;
  logic [bpss_pkg::LEN_W-1:0]  needle_len;
  logic [bpss_pkg::HITS_W-1:0] hit_limit;
  bpss_pkg::reg_index_t        reg_idx;
  logic                        cfg_wr;

  logic             push;
  bpss_pkg::entry_t push_entry;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  bpss_pkg::entry_t q_head;

  // Register file access.
  assign pready  = 1'b1;
  assign reg_idx = bpss_pkg::reg_index_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_lo  <= '0;
      needle_hi  <= '0;
      needle_len <= '0;
      hit_limit  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        bpss_pkg::REG_NEEDLE_LO:  needle_lo  <= pwdata;
        bpss_pkg::REG_NEEDLE_HI:  needle_hi  <= pwdata;
        bpss_pkg::REG_NEEDLE_LEN: needle_len <= pwdata[bpss_pkg::LEN_W-1:0];
        bpss_pkg::REG_HIT_LIMIT:  hit_limit  <= pwdata[bpss_pkg::HITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      bpss_pkg::REG_NEEDLE_LO:  prdata = needle_lo;
      bpss_pkg::REG_NEEDLE_HI:  prdata = needle_hi;
      bpss_pkg::REG_NEEDLE_LEN: prdata = bpss_pkg::CFG_W'(needle_len);
      bpss_pkg::REG_HIT_LIMIT:  prdata = bpss_pkg::CFG_W'(hit_limit);
      default:                  prdata = '0;
    endcase
  end

  // Scanner: window, compare and stream counters.
  bpss_front #(
    .MAX_NEEDLE(MAX_NEEDLE),
    .MAX_HITS  (MAX_HITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_unreadable(byte_unreadable),
    .final_byte     (final_byte),
    .needle_lo      (needle_lo),
    .needle_hi      (needle_hi),
    .needle_len     (needle_len),
    .hit_limit      (hit_limit),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  // Queue between scanner and result stage.
  bpss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Result stage.
  bpss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .is_summary    (is_summary),
    .match_offset  (match_offset),
    .hits_found    (hits_found),
    .saw_unreadable(saw_unreadable),
    .last_of_run   (last_of_run)
  );

endmodule
